@@ sv/smpq_pkg.sv @@
`timescale 1ns / 1ps

package smpq_pkg;

    localparam int CAPACITY_DEF       = 16;
    localparam int VALUE_WIDTH_DEF    = 32;
    localparam int PRIORITY_WIDTH_DEF = 32;

    localparam int FUNC_W   = 2;
    localparam int VAL_W    = 32;
    localparam int PRIO_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_PULL   = 2'd1,
        FUNC_PEEK   = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [VAL_W-1:0]         item_value;
        logic signed [PRIO_W-1:0] item_priority;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    out_value;
        logic                is_empty;
        logic                is_full;
        logic [FILL_W-1:0]   fill_count;
    } t_out_word;

endpackage

@@ sv/stable_max_priority_queue.sv @@
`timescale 1ns / 1ps
// channel  | valid       | stall       | word
// ---------+-------------+-------------+------------
// input    | i_in_valid  | o_in_stall  | i_in_word
// output   | o_out_valid | i_out_stall | o_out_word
//
// insert, unused opcode, or pull/peek on an empty queue: go straight to the finish state
// pull/peek: a scan over all entries, plus on a pull a shift of the entries above the best one,
//   one entry at a time through the single read port of the entry memory and the one key comparator
// input stall is high from acceptance until the result is loaded into the output register
// a result waits in the sequencer while the output register is held by i_out_stall
// synchronous active-low reset empties the queue; entry memory is not cleared

module stable_max_priority_queue
    import smpq_pkg::*;
#(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int VALUE_WIDTH    = VALUE_WIDTH_DEF,
    parameter int PRIORITY_WIDTH = PRIORITY_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = VALUE_WIDTH + PRIORITY_WIDTH;
    localparam logic [PRIORITY_WIDTH-1:0] KEY_FLIP = {1'b1, {(PRIORITY_WIDTH-1){1'b0}}};
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [FUNC_W-1:0]         r_op, n_op;
    t_status                   r_status, n_status;
    logic [VALUE_WIDTH-1:0]    r_value, n_value;
    logic [IW-1:0]             r_ptr, n_ptr;
    logic                      r_rd_on, n_rd_on;
    logic                      r_dv, n_dv;
    logic [IW-1:0]             r_didx, n_didx;
    logic [IW-1:0]             r_best_idx, n_best_idx;
    logic [PRIORITY_WIDTH-1:0] r_best_key, n_best_key;
    logic [VALUE_WIDTH-1:0]    r_best_val, n_best_val;
    logic                      r_out_valid, n_out_valid;
    t_out_word                 r_out_word, n_out_word;

    logic                      we;
    logic [IW-1:0]             waddr;
    logic [EW-1:0]             wdata;
    logic [EW-1:0]             rd_data;
    logic [VALUE_WIDTH-1:0]    rd_val;
    logic [PRIORITY_WIDTH-1:0] rd_key;
    logic [PRIORITY_WIDTH-1:0] in_key;
    logic [VALUE_WIDTH-1:0]    in_val;
    logic [IW-1:0]             last_idx;
    logic                      take;
    logic [IW-1:0]             cur_best_idx;
    logic [VALUE_WIDTH-1:0]    cur_best_val;
    logic                      in_acc;
    logic                      out_free;

    smpq_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    assign rd_val   = rd_data[EW-1:PRIORITY_WIDTH];
    assign rd_key   = rd_data[PRIORITY_WIDTH-1:0];
    assign in_val   = VALUE_WIDTH'(i_in_word.item_value);
    assign in_key   = PRIORITY_WIDTH'($unsigned(i_in_word.item_priority)) ^ KEY_FLIP;
    assign last_idx = IW'(r_count - CW'(1));

    // comparator shared by every entry of the scan, earliest wins on a tie
    assign take         = r_dv && ((r_didx == '0) || (rd_key > r_best_key));
    assign cur_best_idx = take ? r_didx : r_best_idx;
    assign cur_best_val = take ? rd_val : r_best_val;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_on     <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_on     <= n_rd_on;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_status   <= n_status;
        r_value    <= n_value;
        r_ptr      <= n_ptr;
        r_didx     <= n_didx;
        r_best_idx <= n_best_idx;
        r_best_key <= n_best_key;
        r_best_val <= n_best_val;
        r_out_word <= n_out_word;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_status    = r_status;
        n_value     = r_value;
        n_ptr       = r_ptr;
        n_rd_on     = r_rd_on;
        n_dv        = 1'b0;
        n_didx      = r_ptr;
        n_best_idx  = r_best_idx;
        n_best_key  = r_best_key;
        n_best_val  = r_best_val;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        we          = 1'b0;
        waddr       = IW'(r_count);
        wdata       = {in_val, in_key};

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op     = i_in_word.func;
                    n_status = ST_OK;
                    n_value  = '0;
                    n_ptr    = '0;
                    n_rd_on  = 1'b0;
                    n_state  = S_FINISH;
                    if (i_in_word.func == FUNC_INSERT) begin
                        if (r_count == FULL_COUNT) begin
                            n_status = ST_FULL;
                        end else begin
                            we      = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if ((i_in_word.func == FUNC_PULL) ||
                                 (i_in_word.func == FUNC_PEEK)) begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_rd_on = 1'b1;
                            n_state = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                n_dv = r_rd_on;
                if (r_rd_on) begin
                    if (r_ptr == last_idx) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ptr = r_ptr + IW'(1);
                    end
                end
                if (take) begin
                    n_best_idx = r_didx;
                    n_best_key = rd_key;
                    n_best_val = rd_val;
                end
                if (r_dv && (r_didx == last_idx)) begin
                    n_value = cur_best_val;
                    n_dv    = 1'b0;
                    if (r_op == FUNC_PULL) begin
                        if (cur_best_idx == last_idx) begin
                            n_count = r_count - CW'(1);
                            n_state = S_FINISH;
                        end else begin
                            n_ptr   = cur_best_idx + IW'(1);
                            n_rd_on = 1'b1;
                            n_state = S_SHIFT;
                        end
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_SHIFT: begin
                // close the gap: each entry above the pulled one moves down one place
                n_dv = r_rd_on;
                if (r_rd_on) begin
                    if (r_ptr == last_idx) begin
                        n_rd_on = 1'b0;
                    end else begin
                        n_ptr = r_ptr + IW'(1);
                    end
                end
                if (r_dv) begin
                    we    = 1'b1;
                    waddr = r_didx - IW'(1);
                    wdata = rd_data;
                    if (r_didx == last_idx) begin
                        n_dv    = 1'b0;
                        n_count = r_count - CW'(1);
                        n_state = S_FINISH;
                    end
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out_word.status     = r_status;
                    n_out_word.out_value  = VAL_W'(r_value);
                    n_out_word.is_empty   = (r_count == '0);
                    n_out_word.is_full    = (r_count == FULL_COUNT);
                    n_out_word.fill_count = FILL_W'(r_count);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ sv/smpq_ram.sv @@
`timescale 1ns / 1ps

module smpq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import smpq_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RAND_WORDS   = 1000;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 100;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [VAL_W-1:0]  value;
        logic [PRIO_W-1:0] prio;
        int                reps;
        bit                typed;
        t_out_word         want;
    } t_row;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_word  in_word   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_word out_word;

    logic [VAL_W-1:0]         held_values[$];
    logic signed [PRIO_W-1:0] held_prios[$];
    t_out_word                pending_results[$];
    t_row                     dir_rows[$];

    int err_count    = 0;
    int results_seen = 0;
    bit no_gaps      = 1'b0;
    bit hold_done    = 1'b0;

    stable_max_priority_queue u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stable max queue: earliest entry wins among equal priorities
    function automatic t_out_word pq_apply(input t_in_word w);
        t_out_word r;
        int best;
        r = '0;
        r.status = ST_OK;
        case (w.func)
            FUNC_INSERT: begin
                if (held_values.size() >= CAPACITY_DEF) begin
                    r.status = ST_FULL;
                end else begin
                    held_values = {held_values, w.item_value};
                    held_prios  = {held_prios, w.item_priority};
                end
            end
            FUNC_PULL, FUNC_PEEK: begin
                if (held_values.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < held_values.size(); i++) begin
                        if (held_prios[i] > held_prios[best]) best = i;
                    end
                    r.out_value = held_values[best];
                    if (w.func == FUNC_PULL) begin
                        held_values.delete(best);
                        held_prios.delete(best);
                    end
                end
            end
            default: ;
        endcase
        r.is_empty   = (held_values.size() == 0);
        r.is_full    = (held_values.size() >= CAPACITY_DEF);
        r.fill_count = FILL_W'(held_values.size());
        return r;
    endfunction

    function automatic t_in_word rand_word(input bit filling);
        t_in_word w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) w.func = FUNC_UNUSED;
        else if (r < (filling ? 70 : 22)) w.func = FUNC_INSERT;
        else if ($urandom_range(0, 2) != 0) w.func = FUNC_PULL;
        else w.func = FUNC_PEEK;
        r = $urandom_range(0, 99);
        if (r < 5) w.item_value = '0;
        else if (r < 10) w.item_value = '1;
        else w.item_value = $urandom;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            // narrow range so ties are common
            w.item_priority = $urandom_range(0, 6) - 3;
        end else if (r < 50) begin
            case ($urandom_range(0, 3))
                0: w.item_priority = 32'h7FFF_FFFF;
                1: w.item_priority = 32'h8000_0000;
                2: w.item_priority = '0;
                default: w.item_priority = '1;
            endcase
        end else begin
            w.item_priority = $urandom;
        end
        return w;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value,
                           input logic [PRIO_W-1:0] prio, input int reps, input bit typed,
                           input logic [STATUS_W-1:0] st, input logic [VAL_W-1:0] out_v,
                           input logic emp, input logic full, input logic [FILL_W-1:0] cnt);
        t_row row;
        row.func  = func;
        row.value = value;
        row.prio  = prio;
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{status: st, out_value: out_v, is_empty: emp, is_full: full,
                      fill_count: cnt};
        dir_rows = {dir_rows, row};
    endtask

    task automatic offer(input t_in_word w, input bit typed, input t_out_word want);
        int gap;
        t_out_word pred;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        pred = pq_apply(w);
        pending_results = {pending_results, (typed ? want : pred)};
    endtask

    task automatic field_diff(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h got %h", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word %h", $time, out_word);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                field_diff("status", want.status, out_word.status);
                field_diff("out_value", want.out_value, out_word.out_value);
                field_diff("is_empty", want.is_empty, out_word.is_empty);
                field_diff("is_full", want.is_full, out_word.is_full);
                field_diff("fill_count", want.fill_count, out_word.fill_count);
            end
        end
    end

    initial begin : rx_side
        int n;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            // one long hold so the queue backs up into the input
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            n = pick_gap();
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    initial begin : stimulus
        t_row row;
        t_in_word w;
        bit filling;
        filling = 1'b1;

        add_row(FUNC_PEEK, '0, '0, 1, 1, ST_EMPTY, '0, 1, 0, 0);
        add_row(FUNC_PULL, '1, '1, 1, 1, ST_EMPTY, '0, 1, 0, 0);
        add_row(FUNC_UNUSED, 32'h1234_5678, 32'h8765_4321, 1, 1, ST_OK, '0, 1, 0, 0);
        add_row(FUNC_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, 1, ST_OK, '0, 0, 0, 1);
        add_row(FUNC_INSERT, 32'h0, 32'h8000_0000, 1, 1, ST_OK, '0, 0, 0, 2);
        add_row(FUNC_INSERT, 32'h5, 32'h7FFF_FFFF, 1, 1, ST_OK, '0, 0, 0, 3);
        add_row(FUNC_PEEK, '0, '0, 1, 1, ST_OK, 32'hFFFF_FFFF, 0, 0, 3);
        add_row(FUNC_PULL, '0, '0, 1, 1, ST_OK, 32'hFFFF_FFFF, 0, 0, 2);
        add_row(FUNC_PULL, '0, '0, 1, 1, ST_OK, 32'h5, 0, 0, 1);
        add_row(FUNC_PULL, '0, '0, 1, 1, ST_OK, 32'h0, 1, 0, 0);
        add_row(FUNC_INSERT, 32'h1, 32'hFFFF_FFFF, 1, 0, ST_OK, '0, 0, 0, 0);
        add_row(FUNC_INSERT, 32'h2, 32'h0, 1, 0, ST_OK, '0, 0, 0, 0);
        add_row(FUNC_INSERT, 32'h3, 32'hFFFF_FFFF, 1, 0, ST_OK, '0, 0, 0, 0);
        add_row(FUNC_PULL, '0, '0, 2, 0, ST_OK, '0, 0, 0, 0);
        add_row(FUNC_INSERT, 32'h100, 32'h7, 15, 0, ST_OK, '0, 0, 0, 0);
        add_row(FUNC_INSERT, 32'hDEAD_BEEF, 32'h7FFF_FFFF, 1, 1, ST_FULL, '0, 0, 1, 16);
        add_row(FUNC_UNUSED, '1, '1, 1, 1, ST_OK, '0, 0, 1, 16);
        add_row(FUNC_PEEK, '0, '0, 1, 0, ST_OK, '0, 0, 0, 0);
        add_row(FUNC_PULL, '0, '0, 5, 0, ST_OK, '0, 0, 0, 0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            for (int k = 0; k < row.reps; k++) begin
                w.func          = row.func;
                w.item_value    = row.value + k;
                w.item_priority = row.prio;
                offer(w, row.typed, row.want);
            end
        end

        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n % 40 == 0) filling = $urandom_range(0, 1);
            if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            offer(rand_word(filling), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
